// ----- src/bts_pkg.sv -----
// Shared types and constants of the bilinear tile sampler.
`timescale 1ns / 1ps

package bts_pkg;

  // Payload widths fixed by the beat formats
  localparam int unsigned CmdW    = 1;
  localparam int unsigned PosW    = 7;
  localparam int unsigned PixW    = 8;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 1;

  // Tile size after reset, before any clamp to the store size
  localparam int unsigned TileDimReset = 128;

  // Value returned for a coordinate off the tile
  localparam logic [PixW-1:0] BACKGROUND = 8'hFF;

  // Input beat opcodes
  typedef enum logic [CmdW-1:0] {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TILE_WIDTH  = 1'b0,
    REG_TILE_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

// ----- src/bts_if.sv -----
// Valid/ready channel interfaces for the sampler's input and result beats.
`timescale 1ns / 1ps

interface bts_in_if;
  logic                             valid;
  logic                             ready;
  logic [bts_pkg::CmdW-1:0]         cmd;
  logic [bts_pkg::PosW-1:0]         pixel_col;
  logic [bts_pkg::PosW-1:0]         pixel_row;
  logic [bts_pkg::PixW-1:0]         pixel_value;
  logic signed [bts_pkg::CoordW-1:0] sample_x;
  logic signed [bts_pkg::CoordW-1:0] sample_y;

  modport source (
    output valid, cmd, pixel_col, pixel_row, pixel_value, sample_x, sample_y,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_col, pixel_row, pixel_value, sample_x, sample_y,
    output ready
  );
endinterface

interface bts_out_if;
  logic                     valid;
  logic                     ready;
  logic [bts_pkg::PixW-1:0] sample_value;
  logic                     outside_tile;

  modport source (
    output valid, sample_value, outside_tile,
    input  ready
  );
  modport sink (
    input  valid, sample_value, outside_tile,
    output ready
  );
endinterface

// ----- src/bts_bank.sv -----
// One tile bank: simple dual-port RAM, one write and one registered read.
`timescale 1ns / 1ps

module bts_bank #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [bts_pkg::PixW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [bts_pkg::PixW-1:0] rdata_o
);

  logic [bts_pkg::PixW-1:0] mem [Depth];
  logic [bts_pkg::PixW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bilinear_tile_sampler.sv -----
// Top level of the bilinear tile sampler: banked tile store and blend pipeline.
//
//  channel   | dir | beat contents
//  ----------+-----+------------------------------------------------------------
//  req       | in  | cmd, pixel_col, pixel_row, pixel_value, sample_x, sample_y
//  rsp       | out | sample_value, outside_tile (one beat per sample, none per write)
//  cfg_*_i   | in  | register index and data, written when cfg_we_i is high
//
// One beat per cycle sustained while result beats are taken. A sample result passes
// the four parity banks (even/odd row x col), read at its accept edge, then the
// registered x blend of stage 2, then the y blend into the output register.
// A pixel write lands in its bank at its accept edge; no result is produced.
// Reset clears the pipeline valids and sets width and height to 128; the tile
// store is not cleared. req.ready drops only when every stage holds a sample
// and the output beat is not taken.
`timescale 1ns / 1ps

module bilinear_tile_sampler #(
  parameter int unsigned MAX_TILE_W = 128,
  parameter int unsigned MAX_TILE_H = 128,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bts_in_if.sink                      req,
  bts_out_if.source                   rsp,
  input  logic                        cfg_we_i,
  input  logic [bts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bts_pkg::CfgW-1:0]    cfg_data_i
);

  // Derived sizes
  localparam int unsigned DimW  = $clog2(MAX_TILE_W + 1);
  localparam int unsigned DimH  = $clog2(MAX_TILE_H + 1);
  localparam int unsigned XW    = (MAX_TILE_W > 2) ? $clog2(MAX_TILE_W) : 1;
  localparam int unsigned YW    = (MAX_TILE_H > 2) ? $clog2(MAX_TILE_H) : 1;
  localparam int unsigned HalfW = (MAX_TILE_W + 1) / 2;
  localparam int unsigned HalfH = (MAX_TILE_H + 1) / 2;
  localparam int unsigned HcW   = (HalfW > 1) ? $clog2(HalfW) : 1;
  localparam int unsigned HrW   = (HalfH > 1) ? $clog2(HalfH) : 1;
  localparam int unsigned BankD = HalfW * HalfH;
  localparam int unsigned BaW   = (BankD > 1) ? $clog2(BankD) : 1;
  localparam int unsigned BaxW  = BaW + 1;
  localparam int unsigned CW    = bts_pkg::CoordW;
  localparam int unsigned PixW  = bts_pkg::PixW;
  localparam int unsigned RowW  = PixW + FRAC_BITS;
  localparam int unsigned AccW  = PixW + 2 * FRAC_BITS;
  localparam int unsigned RstW  =
      (bts_pkg::TileDimReset > MAX_TILE_W) ? MAX_TILE_W : bts_pkg::TileDimReset;
  localparam int unsigned RstH  =
      (bts_pkg::TileDimReset > MAX_TILE_H) ? MAX_TILE_H : bts_pkg::TileDimReset;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  // Flat bank address from row half and column half
  function automatic logic [BaW-1:0] bank_addr(input logic [HrW-1:0] rh,
                                               input logic [HcW-1:0] ch);
    logic [BaxW-1:0] a;
    a = BaxW'(rh) * BaxW'(HalfW) + BaxW'(ch);
    return BaW'(a);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers, stored already clamped to 1..MAX
  // ---------------------------------------------------------------------------
  logic [DimW-1:0] tile_w_q, w_cfg;
  logic [DimH-1:0] tile_h_q, h_cfg;

  always_comb begin
    if (cfg_data_i == '0) begin
      w_cfg = DimW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_TILE_W)) begin
      w_cfg = DimW'(MAX_TILE_W);
    end else begin
      w_cfg = DimW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      h_cfg = DimH'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_TILE_H)) begin
      h_cfg = DimH'(MAX_TILE_H);
    end else begin
      h_cfg = DimH'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q <= DimW'(RstW);
      tile_h_q <= DimH'(RstH);
    end else if (cfg_we_i) begin
      case (bts_pkg::cfg_reg_e'(cfg_idx_i))
        bts_pkg::REG_TILE_WIDTH:  tile_w_q <= w_cfg;
        bts_pkg::REG_TILE_HEIGHT: tile_h_q <= h_cfg;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when the one after it is free or moving
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, ov_q;
  logic en_o, en2, en1;

  assign en_o      = !ov_q || rsp.ready;
  assign en2       = !v2_q || en_o;
  assign en1       = !v1_q || en2;
  assign req.ready = en1;

  logic acc_beat, is_sample, is_write;
  assign acc_beat  = req.valid && en1;
  assign is_sample = (req.cmd == bts_pkg::CMD_SAMPLE);
  assign is_write  = (req.cmd == bts_pkg::CMD_WRITE);

  // ---------------------------------------------------------------------------
  // Coordinate decode and range check
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] xi_s, yi_s;
  logic [CW-1:0]        xi_u, yi_u, xlim, ylim;
  logic [FRAC_BITS-1:0] dx, dy;
  logic                 x_out, y_out, outside;

  assign xi_s = req.sample_x >>> FRAC_BITS;
  assign yi_s = req.sample_y >>> FRAC_BITS;
  assign xi_u = CW'(xi_s);
  assign yi_u = CW'(yi_s);
  assign dx   = req.sample_x[FRAC_BITS-1:0];
  assign dy   = req.sample_y[FRAC_BITS-1:0];
  assign xlim = CW'(tile_w_q - DimW'(1));
  assign ylim = CW'(tile_h_q - DimH'(1));

  // Past the last column/row only when the integer part is beyond it, or on it
  // with a nonzero fraction
  assign x_out = req.sample_x[CW-1] || (xi_u > xlim) || ((xi_u == xlim) && (dx != '0));
  assign y_out = req.sample_y[CW-1] || (yi_u > ylim) || ((yi_u == ylim) && (dy != '0));
  assign outside = x_out || y_out;

  // Neighbor columns/rows and the bank halves that hold them
  logic [XW-1:0]  x0;
  logic [YW-1:0]  y0;
  logic           clamp_x, clamp_y;
  logic [HcW-1:0] xh, xe_half;
  logic [HrW-1:0] yh, ye_half;

  assign x0      = XW'(xi_u);
  assign y0      = YW'(yi_u);
  assign clamp_x = (x0 == XW'(tile_w_q - DimW'(1)));
  assign clamp_y = (y0 == YW'(tile_h_q - DimH'(1)));
  assign xh      = HcW'(x0 >> 1);
  assign yh      = HrW'(y0 >> 1);
  // Right neighbor of an odd column sits in the next even half
  assign xe_half = (x0[0] && !clamp_x) ? xh + HcW'(1) : xh;
  assign ye_half = (y0[0] && !clamp_y) ? yh + HrW'(1) : yh;

  // ---------------------------------------------------------------------------
  // Four parity banks: [row parity][column parity]
  // ---------------------------------------------------------------------------
  logic           wr_ok, rd_en;
  logic [HcW-1:0] wr_ch;
  logic [HrW-1:0] wr_rh;
  logic [BaW-1:0] wr_addr;
  logic [PixW-1:0] rd_data [2][2];

  assign wr_ok   = acc_beat && is_write &&
                   (32'(req.pixel_col) < 32'(MAX_TILE_W)) &&
                   (32'(req.pixel_row) < 32'(MAX_TILE_H));
  assign wr_ch   = HcW'(req.pixel_col >> 1);
  assign wr_rh   = HrW'(req.pixel_row >> 1);
  assign wr_addr = bank_addr(wr_rh, wr_ch);
  assign rd_en   = acc_beat && is_sample && !outside;

  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar c = 0; c < 2; c++) begin : g_col
      logic [HrW-1:0] rh;
      logic [HcW-1:0] ch;
      logic           we;

      assign rh = (r == 0) ? ye_half : yh;
      assign ch = (c == 0) ? xe_half : xh;
      assign we = wr_ok && (req.pixel_row[0] == 1'(r)) && (req.pixel_col[0] == 1'(c));

      bts_bank #(
        .Depth (BankD),
        .AddrW (BaW)
      ) u_bank (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (wr_addr),
        .wdata_i (req.pixel_value),
        .re_i    (rd_en),
        .raddr_i (bank_addr(rh, ch)),
        .rdata_o (rd_data[r][c])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: bank data arrives; keep fractions and neighbor parities
  // ---------------------------------------------------------------------------
  logic                 out1_q;
  logic [FRAC_BITS-1:0] dx1_q, dy1_q;
  logic                 px_q, pxr_q, py_q, pyb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= acc_beat && is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      out1_q <= outside;
      dx1_q  <= dx;
      dy1_q  <= dy;
      px_q   <= x0[0];
      pxr_q  <= clamp_x ? x0[0] : !x0[0];
      py_q   <= y0[0];
      pyb_q  <= clamp_y ? y0[0] : !y0[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: blend along x for the upper and lower rows
  // ---------------------------------------------------------------------------
  logic [PixW-1:0]      v00, v01, v10, v11;
  logic [FRAC_BITS:0]   wx;
  logic [RowW-1:0]      top_d, bot_d, top_q, bot_q;
  logic                 out2_q;
  logic [FRAC_BITS-1:0] dy2_q;

  assign v00 = rd_data[py_q][px_q];
  assign v01 = rd_data[py_q][pxr_q];
  assign v10 = rd_data[pyb_q][px_q];
  assign v11 = rd_data[pyb_q][pxr_q];
  assign wx  = One - (FRAC_BITS + 1)'(dx1_q);

  assign top_d = RowW'((RowW + 1)'(v00) * (RowW + 1)'(wx) +
                       (RowW + 1)'(v01) * (RowW + 1)'(dx1_q));
  assign bot_d = RowW'((RowW + 1)'(v10) * (RowW + 1)'(wx) +
                       (RowW + 1)'(v11) * (RowW + 1)'(dx1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      out2_q <= out1_q;
      dy2_q  <= dy1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: blend along y, truncate, hold until taken
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS:0] wy;
  logic [AccW-1:0]    acc;
  logic [PixW-1:0]    value_q;
  logic               outside_q;

  assign wy  = One - (FRAC_BITS + 1)'(dy2_q);
  assign acc = AccW'((AccW + 1)'(top_q) * (AccW + 1)'(wy) +
                     (AccW + 1)'(bot_q) * (AccW + 1)'(dy2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      value_q   <= out2_q ? bts_pkg::BACKGROUND : acc[AccW-1:2*FRAC_BITS];
      outside_q <= out2_q;
    end
  end

  assign rsp.valid        = ov_q;
  assign rsp.sample_value = value_q;
  assign rsp.outside_tile = outside_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Back-pressure only comes from a full output beat that is not taken
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req.ready |-> (ov_q && !rsp.ready && v1_q && v2_q))
    else $error("input stalled without a blocked output");

  // A pixel write never enters the blend pipeline
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready && is_write) |=> !v1_q)
    else $error("write beat started a result");

  // A stalled stage 1 keeps its sample
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> (v1_q && $stable(dx1_q) && $stable(dy1_q)))
    else $error("stage 1 sample lost under stall");

  // A clamped neighbor only happens with a zero fraction on that axis
  a_clamp_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !out1_q && (pxr_q == px_q)) |-> (dx1_q == '0))
    else $error("column clamp with nonzero fraction");

  // Off-tile results carry the background level
  a_outside_bg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && outside_q) |-> (value_q == bts_pkg::BACKGROUND))
    else $error("outside sample without background value");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the bilinear tile sampler: directed table plus random traffic.
`timescale 1ns / 1ps

module tb;

  localparam int PosW   = bts_pkg::PosW;
  localparam int PixW   = bts_pkg::PixW;
  localparam int CoordW = bts_pkg::CoordW;
  localparam int CfgW   = bts_pkg::CfgW;

  localparam int TileW      = 128;
  localparam int TileH      = 128;
  localparam int FracBits   = 8;
  localparam int FracOne    = 1 << FracBits;
  localparam int DrainCycles = 6;
  localparam int PhaseCount  = 6;
  localparam int BeatsPerPhase = 170;
  localparam int CycleLimit  = 500000;

  // One input beat, with an optional hand-written expected result
  typedef struct packed {
    bts_pkg::cmd_e     cmd;
    logic [PosW-1:0]   col;
    logic [PosW-1:0]   row;
    logic [PixW-1:0]   value;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic              typed;
    logic [PixW-1:0]   exp_value;
    logic              exp_outside;
  } beat_t;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic            outside;
  } sample_res_t;

  // Directed table: 128x128 tile after reset, corners loaded first
  localparam int DirN = 22;
  localparam beat_t DIRECTED [DirN] = '{
    '{bts_pkg::CMD_WRITE,  7'd0,   7'd0,   8'd200, 16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd1,   7'd0,   8'd100, 16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd0,   7'd1,   8'd50,  16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd1,   7'd1,   8'd255, 16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd126, 7'd126, 8'd7,   16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd127, 7'd126, 8'd0,   16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd126, 7'd127, 8'd0,   16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_WRITE,  7'd127, 7'd127, 8'd255, 16'h0000, 16'h0000, 1'b0, 8'd0,   1'b0},
    // exact pixel hits and fractional blends
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h0000, 16'h0000, 1'b1, 8'd200, 1'b0},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h0080, 16'h0000, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h00FF, 16'h00FF, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h0040, 16'h00C0, 1'b0, 8'd0,   1'b0},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h7E00, 16'h7E00, 1'b1, 8'd7,   1'b0},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h7E80, 16'h7E80, 1'b0, 8'd0,   1'b0},
    // last column: right neighbor clamps to itself
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h7F00, 16'h7E40, 1'b0, 8'd0,   1'b0},
    // exact far corner is still inside
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h7F00, 16'h7F00, 1'b1, 8'd255, 1'b0},
    // off-tile coordinates return background with the flag
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'hFFFF, 16'h0000, 1'b1, 8'd255, 1'b1},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h0000, 16'h8000, 1'b1, 8'd255, 1'b1},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h7F01, 16'h0000, 1'b1, 8'd255, 1'b1},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h0000, 16'h7F01, 1'b1, 8'd255, 1'b1},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h7FFF, 16'h7FFF, 1'b1, 8'd255, 1'b1},
    '{bts_pkg::CMD_SAMPLE, 7'd0,   7'd0,   8'd0,   16'h8000, 16'h8000, 1'b1, 8'd255, 1'b1}
  };

  // Tile sizes per random phase, out-of-range values included
  localparam logic [CfgW-1:0] PHASE_W [PhaseCount] = '{8'd200, 8'd1, 8'd0, 8'd128, 8'd37, 8'd2};
  localparam logic [CfgW-1:0] PHASE_H [PhaseCount] = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd91, 8'd128};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic              cfg_we_i;
  bts_pkg::cfg_reg_e cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;

  bts_in_if  req_ch ();
  bts_out_if rsp_ch ();

  // Hand-written expectation travelling with the beat on the bus
  logic            cur_typed;
  logic [PixW-1:0] cur_exp_value;
  logic            cur_exp_outside;

  // Shadow of the block: registers, tile contents, pixels planned so far
  logic [CfgW-1:0] tile_w_reg = CfgW'(bts_pkg::TileDimReset);
  logic [CfgW-1:0] tile_h_reg = CfgW'(bts_pkg::TileDimReset);
  logic [PixW-1:0] tile_img   [TileW*TileH];
  bit              pix_known  [TileW*TileH];

  sample_res_t sample_q [$];
  sample_res_t want;
  int err_cnt = 0;
  int src_idle_pct = 13;
  int dst_idle_pct = 57;
  int cycle_cnt = 0;

  bilinear_tile_sampler #(
    .MAX_TILE_W (TileW),
    .MAX_TILE_H (TileH),
    .FRAC_BITS  (FracBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register value as the block uses it: 0 acts as 1, large values clamp
  function automatic int tile_dim(logic [CfgW-1:0] v, int max_dim);
    if (v == 0) return 1;
    if (int'(v) > max_dim) return max_dim;
    return int'(v);
  endfunction

  function automatic bit in_tile(int x, int y);
    return x >= 0 && y >= 0 &&
           x <= (tile_dim(tile_w_reg, TileW) - 1) * FracOne &&
           y <= (tile_dim(tile_h_reg, TileH) - 1) * FracOne;
  endfunction

  // Right or lower neighbor, clamped at the last column or row
  function automatic int next_idx(int i, int dim);
    return (i + 1 < dim) ? i + 1 : i;
  endfunction

  function automatic longint pix_at(int col, int row);
    return longint'(tile_img[row * TileW + col]);
  endfunction

  // Bilinear blend with 8-bit fraction weights, floor of the exact sum
  function automatic sample_res_t blend_sample(int x, int y);
    int x0, y0, x1, y1;
    longint dx, dy, top, bot, acc;
    sample_res_t r;
    if (!in_tile(x, y)) begin
      r.value   = bts_pkg::BACKGROUND;
      r.outside = 1'b1;
      return r;
    end
    x0 = x >> FracBits;
    y0 = y >> FracBits;
    dx = x & (FracOne - 1);
    dy = y & (FracOne - 1);
    x1 = next_idx(x0, tile_dim(tile_w_reg, TileW));
    y1 = next_idx(y0, tile_dim(tile_h_reg, TileH));
    top = pix_at(x0, y0) * (FracOne - dx) + pix_at(x1, y0) * dx;
    bot = pix_at(x0, y1) * (FracOne - dx) + pix_at(x1, y1) * dx;
    acc = top * (FracOne - dy) + bot * dy;
    r.value   = acc[2*FracBits +: PixW];
    r.outside = 1'b0;
    return r;
  endfunction

  // Input side: register writes, pixel writes and expected samples
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bts_pkg::REG_TILE_WIDTH:  tile_w_reg = cfg_data_i;
          bts_pkg::REG_TILE_HEIGHT: tile_h_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.cmd == bts_pkg::CMD_WRITE) begin
          tile_img[int'(req_ch.pixel_row) * TileW + int'(req_ch.pixel_col)] =
            req_ch.pixel_value;
        end else if (cur_typed) begin
          sample_q.push_back(sample_res_t'{cur_exp_value, cur_exp_outside});
        end else begin
          sample_q.push_back(blend_sample(req_ch.sample_x, req_ch.sample_y));
        end
      end
    end
  end

  // Result side: compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (sample_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with nothing expected: expected none, actual %0d/%0b",
                 $time, rsp_ch.sample_value, rsp_ch.outside_tile);
      end else begin
        want = sample_q.pop_front();
        if (rsp_ch.sample_value !== want.value) begin
          err_cnt++;
          $display("%0t: sample_value mismatch: expected %0d, actual %0d",
                   $time, want.value, rsp_ch.sample_value);
        end
        if (rsp_ch.outside_tile !== want.outside) begin
          err_cnt++;
          $display("%0t: outside_tile mismatch: expected %0b, actual %0b",
                   $time, want.outside, rsp_ch.outside_tile);
        end
      end
    end
  end

  // Receiver: random back-pressure at the current rate
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one beat, with random gaps ahead of it, and wait for the accept
  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= b.cmd;
    req_ch.pixel_col   <= b.col;
    req_ch.pixel_row   <= b.row;
    req_ch.pixel_value <= b.value;
    req_ch.sample_x    <= b.sx;
    req_ch.sample_y    <= b.sy;
    cur_typed          <= b.typed;
    cur_exp_value      <= b.exp_value;
    cur_exp_outside    <= b.exp_outside;
    if (b.cmd == bts_pkg::CMD_WRITE) pix_known[int'(b.row) * TileW + int'(b.col)] = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic send_pixel(int col, int row, int value);
    beat_t b;
    b = '0;
    b.cmd   = bts_pkg::CMD_WRITE;
    b.col   = PosW'(col);
    b.row   = PosW'(row);
    b.value = PixW'(value);
    send_beat(b);
  endtask

  task automatic load_if_unknown(int col, int row);
    if (!pix_known[row * TileW + col]) send_pixel(col, row, $urandom_range(255));
  endtask

  // Load any missing neighbor first so no unwritten pixel is ever read
  task automatic send_sample(int x, int y);
    int x0, y0, x1, y1;
    beat_t b;
    if (in_tile(x, y)) begin
      x0 = x >> FracBits;
      y0 = y >> FracBits;
      x1 = next_idx(x0, tile_dim(tile_w_reg, TileW));
      y1 = next_idx(y0, tile_dim(tile_h_reg, TileH));
      load_if_unknown(x0, y0);
      load_if_unknown(x1, y0);
      load_if_unknown(x0, y1);
      load_if_unknown(x1, y1);
    end
    b = '0;
    b.cmd = bts_pkg::CMD_SAMPLE;
    b.sx  = CoordW'(x);
    b.sy  = CoordW'(y);
    send_beat(b);
  endtask

  // Mix of pixel loads, in-tile samples, edge probes and wild coordinates
  task automatic random_beat();
    int xmax, ymax, x, y, pick, tmp;
    xmax = (tile_dim(tile_w_reg, TileW) - 1) * FracOne;
    ymax = (tile_dim(tile_h_reg, TileH) - 1) * FracOne;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_pixel($urandom_range(TileW - 1), $urandom_range(TileH - 1), $urandom_range(255));
      return;
    end
    if (pick < 35) begin
      x = int'($urandom_range(65535)) - 32768;
      y = int'($urandom_range(65535)) - 32768;
    end else if (pick < 45) begin
      case ($urandom_range(3))
        0:       x = -1;
        1:       x = 0;
        2:       x = xmax;
        default: x = xmax + 1;
      endcase
      y = $urandom_range(ymax);
      if ($urandom_range(1)) begin
        x = x * (ymax + FracOne) / (xmax + FracOne);
        tmp = y % (xmax + 1);
        y = x;
        x = tmp;
        case ($urandom_range(3))
          0:       y = -1;
          1:       y = 0;
          2:       y = ymax;
          default: y = ymax + 1;
        endcase
      end
    end else begin
      x = $urandom_range(xmax);
      y = $urandom_range(ymax);
    end
    send_sample(x, y);
  endtask

  // Stop sending and let every expected result come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both sizes, then wait with the write enable low so the shadow holds the new sizes
  task automatic set_tile(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bts_pkg::REG_TILE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= bts_pkg::REG_TILE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    req_ch.valid       = 1'b0;
    req_ch.cmd         = bts_pkg::CMD_WRITE;
    req_ch.pixel_col   = '0;
    req_ch.pixel_row   = '0;
    req_ch.pixel_value = '0;
    req_ch.sample_x    = '0;
    req_ch.sample_y    = '0;
    cur_typed          = 1'b0;
    cur_exp_value      = '0;
    cur_exp_outside    = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = bts_pkg::REG_TILE_WIDTH;
    cfg_data_i         = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_beat(DIRECTED[i]);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      set_tile(PHASE_W[p], PHASE_H[p]);
      // sender-light, then receiver-light, then no idling at all
      case (p / 2)
        0:       begin src_idle_pct = 13; dst_idle_pct = 57; end
        1:       begin src_idle_pct = 57; dst_idle_pct = 13; end
        default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
      endcase
      for (int k = 0; k < BeatsPerPhase; k++) begin
        if (p == 0 && k == BeatsPerPhase / 2) drain_results();
        random_beat();
      end
    end
    drain_results();

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
